@@ rtl/wgm_pkg.sv @@
package wgm_pkg;

    // Pattern store depth and the width of a count that can hold it.
    localparam int PAT_LEN = 64;
    localparam int LEN_W   = $clog2(PAT_LEN + 1);

    // Request commands.
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_TEXT   = 2'd2;
    localparam logic [1:0] CMD_END    = 2'd3;

    // Special pattern bytes and the ASCII case distance.
    localparam logic [7:0] STAR_BYTE  = 8'h2A;
    localparam logic [7:0] QUEST_BYTE = 8'h3F;
    localparam logic [7:0] CASE_GAP   = 8'h20;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] UPPER_Z    = 8'h5A;

    // Configuration register addresses.
    localparam logic [2:0] ADDR_CASE_SENSITIVE = 3'd0;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] char_value;
    } t_in_req;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } t_out_req;

    // Control shared by every cell.
    typedef struct packed {
        logic       restart;
        logic       text_en;
        logic       case_sens;
        logic [7:0] text_byte;
    } t_cell_ctl;

    // Control that differs from cell to cell.
    typedef struct packed {
        logic active;
        logic at_end;
        logic wr_en;
        logic live_init;
    } t_cell_sel;

    // Fold ASCII upper case to lower case when case-insensitive.
    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic cs);
        logic [7:0] res;
        res = b;
        if (!cs && b >= UPPER_A && b <= UPPER_Z) begin
            res = b + CASE_GAP;
        end
        return res;
    endfunction

endpackage

@@ rtl/wgm_cell.sv @@
module wgm_cell
    import wgm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_cell_sel i_sel,
    input  logic [7:0] i_wr_byte,
    input  logic      i_carry,
    input  logic      i_step,
    output logic      o_carry,
    output logic      o_step,
    output logic      o_hit
);

    logic [7:0] r_char;
    logic       r_live;
    logic       n_live;
    logic       w_closed;
    logic       w_star;
    logic       w_single;

    // A live star ahead of this cell also makes this position live.
    assign w_closed = r_live | i_carry;
    assign w_star   = (r_char == STAR_BYTE);
    assign w_single = (r_char == QUEST_BYTE) ||
                      (fold_byte(r_char, i_ctl.case_sens) == i_ctl.text_byte);

    assign o_carry = w_closed & i_sel.active & w_star;
    assign o_step  = w_closed & i_sel.active & ~w_star & w_single;
    assign o_hit   = w_closed & i_sel.at_end;

    // A star keeps its own position; a consumed byte arrives from the left.
    always_comb begin
        n_live = r_live;
        if (i_ctl.restart) begin
            n_live = i_sel.live_init;
        end else if (i_ctl.text_en) begin
            n_live = o_carry | i_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= i_sel.live_init;
        end else begin
            r_live <= n_live;
        end
    end

    // Pattern byte, loaded when the append lands on this cell.
    always_ff @(posedge i_clk) begin
        if (i_sel.wr_en) begin
            r_char <= i_wr_byte;
        end
    end

endmodule

@@ rtl/wildcard_glob_matcher_top.sv @@
// A result is written to the output register when its end-of-text request is accepted.
// One request per cycle unless stalled; every cell updates its live bit in parallel.
// The longest path is the star closure rippling along the row of cells.
// An end-of-text request waits only while an earlier result is held by stall.
// Reset (synchronous, active low): empty pattern, only position 0 live, no overflow,
// case-sensitive compare; the pattern bytes themselves are not cleared.
module wildcard_glob_matcher_top
    import wgm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_req     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_req    o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic             r_case_sens;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic             r_ovf;
    logic             n_ovf;
    logic             r_live_end;
    logic             n_live_end;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_req         r_out;
    logic             w_accept;
    logic             w_restart;
    logic             w_text;
    logic             w_append_ok;
    logic             w_closed_end;
    logic             w_hit;
    t_cell_ctl        w_ctl;
    logic [PAT_LEN:0] w_carry;
    logic [PAT_LEN:0] w_step;
    logic [PAT_LEN-1:0] w_hit_vec;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CASE_SENSITIVE) ? {31'd0, r_case_sens} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_case_sens <= 1'b1;
        end else if (psel && penable && pwrite && paddr == ADDR_CASE_SENSITIVE) begin
            r_case_sens <= pwdata[0];
        end
    end

    // Handshake: only an end-of-text request needs room in the output register.
    assign o_in_stall = r_out_valid && i_out_stall && (i_in_data.cmd == CMD_END);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_text     = w_accept && (i_in_data.cmd == CMD_TEXT);
    assign w_restart  = w_accept && (i_in_data.cmd != CMD_TEXT);
    assign w_append_ok = (r_len < LEN_W'(PAT_LEN));

    assign w_ctl.restart   = w_restart;
    assign w_ctl.text_en   = w_text;
    assign w_ctl.case_sens = r_case_sens;
    assign w_ctl.text_byte = fold_byte(i_in_data.char_value, r_case_sens);

    assign w_carry[0] = 1'b0;
    assign w_step[0]  = 1'b0;

    // Row of pattern cells.
    for (genvar g = 0; g < PAT_LEN; g++) begin : g_cell
        t_cell_sel w_sel;
        assign w_sel.active    = (r_len > LEN_W'(g));
        assign w_sel.at_end    = (r_len == LEN_W'(g));
        assign w_sel.wr_en     = w_accept && (i_in_data.cmd == CMD_APPEND) &&
                                 (r_len == LEN_W'(g));
        assign w_sel.live_init = (g == 0);

        wgm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_sel     (w_sel),
            .i_wr_byte (i_in_data.char_value),
            .i_carry   (w_carry[g]),
            .i_step    (w_step[g]),
            .o_carry   (w_carry[g+1]),
            .o_step    (w_step[g+1]),
            .o_hit     (w_hit_vec[g])
        );
    end

    // Final position, past the last pattern byte.
    assign w_closed_end = r_live_end | w_carry[PAT_LEN];
    assign w_hit = (|w_hit_vec) || (w_closed_end && r_len == LEN_W'(PAT_LEN));

    // Pattern length, overflow flag and final live bit.
    always_comb begin
        n_len      = r_len;
        n_ovf      = r_ovf;
        n_live_end = r_live_end;
        if (w_restart) begin
            n_live_end = 1'b0;
        end else if (w_text) begin
            n_live_end = w_step[PAT_LEN];
        end
        if (w_accept && i_in_data.cmd == CMD_CLEAR) begin
            n_len = '0;
            n_ovf = 1'b0;
        end else if (w_accept && i_in_data.cmd == CMD_APPEND) begin
            if (w_append_ok) begin
                n_len = r_len + LEN_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_ovf      <= 1'b0;
            r_live_end <= 1'b0;
        end else begin
            r_len      <= n_len;
            r_ovf      <= n_ovf;
            r_live_end <= n_live_end;
        end
    end

    // Output register.
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (w_accept && i_in_data.cmd == CMD_END) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_in_data.cmd == CMD_END) begin
            r_out.matched          <= w_hit && !r_ovf;
            r_out.pattern_overflow <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The pattern length never passes the store depth.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(PAT_LEN))
        else $error("pattern length beyond store depth");

    // An overflowed pattern never reports a match.
    a_ovf_nomatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.matched && o_out_data.pattern_overflow))
        else $error("match reported with overflow");

    // An accepted end of text yields a result in the next cycle.
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.cmd == CMD_END) |=> o_out_valid)
        else $error("end of text gave no result");

    // A clear empties the pattern and the overflow flag.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.cmd == CMD_CLEAR) |=> (r_len == '0 && !r_ovf))
        else $error("clear did not empty the pattern");

endmodule

@@ sim/wildcard_glob_matcher_top_tb.sv @@
`timescale 1ns / 1ps

module wildcard_glob_matcher_top_tb
    import wgm_pkg::*;
();

    // Clock, reset and block ports; every input starts at a known value.
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_req     i_in_data   = '0;
    logic        i_out_stall = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_req    o_out_data;
    logic [31:0] prdata;
    logic        pready;

    wildcard_glob_matcher_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Idle rates in percent for the request sender and the result receiver.
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;

    // Bookkeeping.
    int unsigned fail_count      = 0;
    int unsigned items_sent      = 0;
    int unsigned results_checked = 0;

    // Start set: only position 0 live.
    localparam logic [PAT_LEN:0] START_SET = {{PAT_LEN{1'b0}}, 1'b1};

    // Shadow copy of the matcher state.
    logic [7:0]       pat_bytes [PAT_LEN];
    int unsigned      pat_count = 0;
    logic [PAT_LEN:0] live_set  = START_SET;
    logic             ovf_seen  = 1'b0;
    logic             exact_cmp = 1'b1;

    // Verdicts still owed by the block, oldest first.
    t_out_req verdict_queue [$];

    // Text built for the current random sequence.
    logic [7:0] text_bytes [$];

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest legal run.
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Fold A-Z onto a-z when the compare is case-insensitive.
    function automatic logic [7:0] lower_ascii(input logic [7:0] b);
        if (!exact_cmp && b >= UPPER_A && b <= UPPER_Z) begin
            return b + CASE_GAP;
        end
        return b;
    endfunction

    // A live position that holds a star also makes the next position live.
    function automatic logic [PAT_LEN:0] star_closure(input logic [PAT_LEN:0] set);
        logic [PAT_LEN:0] res;
        res = set;
        for (int i = 0; i < pat_count; i++) begin
            if (res[i] && pat_bytes[i] == STAR_BYTE) begin
                res[i + 1] = 1'b1;
            end
        end
        return res;
    endfunction

    // Advance the shadow state by one accepted request.
    function automatic void track_request(input t_in_req req);
        logic [PAT_LEN:0] seen;
        logic [PAT_LEN:0] nxt;
        logic [7:0]       tb;
        t_out_req         res;
        case (req.cmd)
            CMD_CLEAR: begin
                pat_count = 0;
                ovf_seen  = 1'b0;
                live_set  = START_SET;
            end
            CMD_APPEND: begin
                if (pat_count < PAT_LEN) begin
                    pat_bytes[pat_count] = req.char_value;
                    pat_count++;
                end else begin
                    ovf_seen = 1'b1;
                end
                live_set = START_SET;
            end
            CMD_TEXT: begin
                seen = star_closure(live_set);
                nxt  = '0;
                tb   = lower_ascii(req.char_value);
                for (int i = 0; i < pat_count; i++) begin
                    if (seen[i]) begin
                        if (pat_bytes[i] == STAR_BYTE) begin
                            nxt[i] = 1'b1;
                        end else if (pat_bytes[i] == QUEST_BYTE ||
                                     lower_ascii(pat_bytes[i]) == tb) begin
                            nxt[i + 1] = 1'b1;
                        end
                    end
                end
                live_set = nxt;
            end
            default: begin
                seen                 = star_closure(live_set);
                res.matched          = seen[pat_count] && !ovf_seen;
                res.pattern_overflow = ovf_seen;
                verdict_queue.push_back(res);
                live_set = START_SET;
            end
        endcase
    endfunction

    // Send one request, idling first at the current rate, and wait for acceptance.
    task automatic send_request(input logic [1:0] cmd, input logic [7:0] ch);
        t_in_req req;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        req.cmd        = cmd;
        req.char_value = ch;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        track_request(req);
        items_sent++;
    endtask

    // Drain all verdicts and let the pipeline empty before a register access.
    task automatic settle_for_config();
        i_in_valid <= 1'b0;
        while (verdict_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the case mode register over the APB port, then read it back.
    task automatic write_case_mode(input logic value);
        logic [31:0] rd;
        settle_for_config();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CASE_SENSITIVE;
        pwdata  <= {31'b0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        exact_cmp = value;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[0] !== value) begin
            $display("%0t: case mode readback expected %0b actual %0b", $time, value, rd[0]);
            fail_count++;
        end
        @(posedge i_clk);
    endtask

    // Replace the pattern with the given string.
    task automatic load_pattern(input string s);
        send_request(CMD_CLEAR, 8'h00);
        for (int i = 0; i < s.len(); i++) begin
            send_request(CMD_APPEND, s[i]);
        end
    endtask

    // Stream a text string and close it with end of text.
    task automatic match_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_request(CMD_TEXT, s[i]);
        end
        send_request(CMD_END, 8'h00);
    endtask

    // Pattern bytes lean on wildcards and a few letters, with any byte now and then.
    function automatic logic [7:0] pick_pattern_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20) begin
            return STAR_BYTE;
        end else if (r < 35) begin
            return QUEST_BYTE;
        end else if (r < 80) begin
            return (r[0] ? 8'h61 : 8'h62) ^ (r[1] ? CASE_GAP : 8'h00);
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) begin
            return (r[0] ? 8'h61 : 8'h62) ^ (r[1] ? CASE_GAP : 8'h00);
        end
        return 8'($urandom_range(255));
    endfunction

    // Build a text that the stored pattern likely matches, then maybe damage it.
    function automatic void build_text();
        logic [7:0]  p;
        int unsigned r;
        text_bytes.delete();
        for (int i = 0; i < pat_count; i++) begin
            p = pat_bytes[i];
            if (p == STAR_BYTE) begin
                repeat ($urandom_range(0, 2)) text_bytes.push_back(pick_text_byte());
            end else if (p == QUEST_BYTE) begin
                text_bytes.push_back(pick_text_byte());
            end else if (((p | CASE_GAP) >= 8'h61) && ((p | CASE_GAP) <= 8'h7A) &&
                         $urandom_range(1) == 1) begin
                text_bytes.push_back(p ^ CASE_GAP);
            end else begin
                text_bytes.push_back(p);
            end
        end
        r = $urandom_range(99);
        if (r < 10 && text_bytes.size() != 0) begin
            text_bytes.delete($urandom_range(text_bytes.size() - 1));
        end else if (r < 20 && text_bytes.size() != 0) begin
            text_bytes[$urandom_range(text_bytes.size() - 1)] = pick_text_byte();
        end else if (r < 25) begin
            text_bytes.insert($urandom_range(text_bytes.size()), pick_text_byte());
        end
    endfunction

    // Result side: random stall and a check of every accepted verdict.
    always @(posedge i_clk) begin
        t_out_req want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_queue.size() == 0) begin
                $display("%0t: unexpected verdict matched=%0b overflow=%0b", $time,
                         o_out_data.matched, o_out_data.pattern_overflow);
                fail_count++;
            end else begin
                want = verdict_queue.pop_front();
                results_checked++;
                if (o_out_data.matched !== want.matched) begin
                    $display("%0t: matched expected %0b actual %0b", $time,
                             want.matched, o_out_data.matched);
                    fail_count++;
                end
                if (o_out_data.pattern_overflow !== want.pattern_overflow) begin
                    $display("%0t: pattern_overflow expected %0b actual %0b", $time,
                             want.pattern_overflow, o_out_data.pattern_overflow);
                    fail_count++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Empty cases, wildcards, extreme bytes, a pattern change mid-text.
    task automatic test_directed();
        send_request(CMD_CLEAR, 8'hFF);
        match_text("");
        match_text("a");
        load_pattern("*");
        match_text("");
        match_text("x");
        load_pattern("a?c");
        match_text("abc");
        match_text("ab");
        send_request(CMD_TEXT, "a");
        send_request(CMD_APPEND, "d");
        match_text("abcd");
        send_request(CMD_CLEAR, 8'h00);
        send_request(CMD_APPEND, 8'h00);
        send_request(CMD_APPEND, 8'hFF);
        send_request(CMD_TEXT, 8'h00);
        send_request(CMD_TEXT, 8'hFF);
        send_request(CMD_END, 8'hFF);
        load_pattern("A");
        match_text("a");
    endtask

    // Fill the store exactly, match against it, then overrun it and clear again.
    task automatic test_store_full();
        send_request(CMD_CLEAR, 8'h00);
        for (int i = 0; i < PAT_LEN; i++) begin
            send_request(CMD_APPEND, 8'(i));
        end
        for (int i = 0; i < PAT_LEN; i++) begin
            send_request(CMD_TEXT, 8'(i));
        end
        send_request(CMD_END, 8'h00);
        send_request(CMD_APPEND, "z");
        for (int i = 0; i < PAT_LEN; i++) begin
            send_request(CMD_TEXT, 8'(i));
        end
        send_request(CMD_END, 8'h00);
        send_request(CMD_CLEAR, 8'h00);
        send_request(CMD_END, 8'h00);
    endtask

    // Case-insensitive compare: letters fold, neighbors and high bytes do not.
    task automatic test_case_fold();
        load_pattern("AbZ@[");
        match_text("aBz@[");
        match_text("aBz`{");
        load_pattern("*\xC1?");
        match_text("q\xE1Q");
        match_text("Q\xC1q");
    endtask

    // Well-formed pattern and text sequences, with some noise mixed in.
    task automatic test_random_traffic(input int unsigned budget);
        int unsigned start;
        int unsigned plen;
        int unsigned texts;
        start = items_sent;
        while (items_sent - start < budget) begin
            if ($urandom_range(99) < 8) begin
                send_request(2'($urandom_range(3)), 8'($urandom_range(255)));
            end else begin
                if ($urandom_range(99) < 80) begin
                    send_request(CMD_CLEAR, 8'($urandom_range(255)));
                end
                if ($urandom_range(99) < 3) begin
                    plen  = $urandom_range(PAT_LEN - 4, PAT_LEN + 2);
                    texts = 1;
                end else begin
                    plen  = $urandom_range(0, 6);
                    texts = $urandom_range(1, 3);
                end
                repeat (plen) send_request(CMD_APPEND, pick_pattern_byte());
                repeat (texts) begin
                    build_text();
                    foreach (text_bytes[k]) begin
                        if ($urandom_range(99) == 0) begin
                            send_request(CMD_APPEND, pick_pattern_byte());
                        end
                        send_request(CMD_TEXT, text_bytes[k]);
                    end
                    send_request(CMD_END, 8'($urandom_range(255)));
                end
            end
        end
    endtask

    // Test sequence.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles less than the receiver stalls.
        idle_pct  = 29;
        stall_pct = 51;
        test_directed();
        test_store_full();
        write_case_mode(1'b0);
        test_case_fold();
        test_random_traffic(100);

        // Sender idles more than the receiver stalls.
        write_case_mode(1'b1);
        idle_pct  = 51;
        stall_pct = 29;
        test_random_traffic(100);

        // Back to back in both directions.
        write_case_mode(1'b0);
        idle_pct  = 0;
        stall_pct = 0;
        test_random_traffic(100);
        write_case_mode(1'b1);
        test_random_traffic(40);

        // Wait for the last verdicts, then let the pipeline settle.
        i_in_valid <= 1'b0;
        while (verdict_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Covered %0d requests and %0d verdicts, both case modes, three idle profiles,",
                 items_sent, results_checked);
        $display("an exactly full and an overrun pattern store, and pattern changes mid-text.");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
